/* design/stx_pkg.sv */
// stx_pkg: types, codes and character constants for the s-expression tokenizer.
// No dependencies; every other design file except stx_if.sv imports it.

package stx_pkg;

    typedef enum logic [2:0] {
        ST_WS       = 3'd0,
        ST_COMMENT  = 3'd1,
        ST_ATOM     = 3'd2,
        ST_ATOM_ESC = 3'd3,
        ST_STR      = 3'd4,
        ST_STR_ESC  = 3'd5
    } scan_state_t;

    localparam logic [1:0] KIND_PUNCT  = 2'd0;
    localparam logic [1:0] KIND_ATOM   = 2'd1;
    localparam logic [1:0] KIND_STRING = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [1:0] LIT_NONE  = 2'd0;
    localparam logic [1:0] LIT_TRUE  = 2'd1;
    localparam logic [1:0] LIT_FALSE = 2'd2;
    localparam logic [1:0] LIT_CHAR  = 2'd3;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_END_STRING = 2'd1;
    localparam logic [1:0] ERR_END_ESCAPE = 2'd2;

    localparam logic MODE_TEXT = 1'b0;
    localparam logic MODE_END  = 1'b1;

    localparam int          TAB_WIDTH_BITS = 5;
    localparam logic [4:0]  TAB_RESET      = 5'd8;
    localparam int          LEN_BITS       = 16;
    localparam logic [15:0] LEN_MAX        = 16'hFFFF;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_T   = 8'h54;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_T   = 8'h74;

    // Lexer control state that is independent of the position widths.
    typedef struct packed {
        scan_state_t     scan_state;
        logic            pend_valid;
        logic [15:0]     tok_length;
        logic [2:0][7:0] first_chars;
    } lex_ctl_t;

    localparam lex_ctl_t CTL_RESET = '{ST_WS, 1'b0, 16'd0, 24'd0};

    // What one byte does: next control state, token start update, result.
    typedef struct packed {
        lex_ctl_t    ctl;
        logic        clear;
        logic        mark_pre;
        logic        mark_post;
        logic        emit;
        logic [1:0]  kind;
        logic [15:0] length;
        logic [1:0]  lit_class;
        logic [7:0]  lit_char;
        logic [1:0]  err;
    } step_t;

endpackage

/* design/stx_if.sv */
// stx_in_if / stx_out_if: valid-ready channels for text bytes and tokens.
// Depends on nothing; the position widths of the token channel follow its parameters.

interface stx_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] text_byte;

    modport source (output valid, output mode, output text_byte, input ready);
    modport sink   (input valid, input mode, input text_byte, output ready);
endinterface

interface stx_out_if #(
    parameter int OFFSET_WIDTH = 24,
    parameter int ROW_WIDTH    = 20,
    parameter int COL_WIDTH    = 16
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              token_kind;
    logic [OFFSET_WIDTH-1:0] start_offset;
    logic [15:0]             token_length;
    logic [ROW_WIDTH-1:0]    start_row;
    logic [COL_WIDTH-1:0]    start_column;
    logic [1:0]              literal_class;
    logic [7:0]              literal_char;
    logic [1:0]              error_code;

    modport source (
        output valid, output token_kind, output start_offset, output token_length,
        output start_row, output start_column, output literal_class,
        output literal_char, output error_code, input ready
    );
    modport sink (
        input valid, input token_kind, input start_offset, input token_length,
        input start_row, input start_column, input literal_class,
        input literal_char, input error_code, output ready
    );
endinterface

/* design/stx_pos.sv */
// stx_pos: saturating position advance (offset, row, column) for one byte.
// Depends on stx_pkg for character and tab constants.

module stx_pos
    import stx_pkg::*;
#(
    parameter int OFFSET_WIDTH = 24,
    parameter int ROW_WIDTH    = 20,
    parameter int COL_WIDTH    = 16
) (
    input  logic [OFFSET_WIDTH-1:0]   cur_offset,
    input  logic [ROW_WIDTH-1:0]      cur_row,
    input  logic [COL_WIDTH-1:0]      cur_column,
    input  logic [7:0]                text_byte,
    input  logic [TAB_WIDTH_BITS-1:0] tab_width,
    output logic [OFFSET_WIDTH-1:0]   adv_offset,
    output logic [ROW_WIDTH-1:0]      adv_row,
    output logic [COL_WIDTH-1:0]      adv_column
);

    logic [COL_WIDTH:0] col_step;
    logic [COL_WIDTH:0] col_sum;

    assign adv_offset = (&cur_offset) ? cur_offset : cur_offset + 1'b1;

    always_comb
    begin
        if (text_byte == CH_TAB)
        begin
            col_step = (COL_WIDTH+1)'(tab_width);
        end
        else
        begin
            col_step = (COL_WIDTH+1)'(1);
        end
        col_sum = {1'b0, cur_column} + col_step;

        if (text_byte == CH_NL)
        begin
            adv_row    = (&cur_row) ? cur_row : cur_row + 1'b1;
            adv_column = '0;
        end
        else
        begin
            adv_row    = cur_row;
            adv_column = col_sum[COL_WIDTH] ? {COL_WIDTH{1'b1}} : col_sum[COL_WIDTH-1:0];
        end
    end

endmodule

/* design/stx_step.sv */
// stx_step: lexer transition for one request: next control state, token
// start marking and the token result. Depends on stx_pkg.

module stx_step
    import stx_pkg::*;
(
    input  lex_ctl_t   ctl,
    input  logic       mode,
    input  logic [7:0] text_byte,
    output step_t      res
);

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c == CH_LPAREN || c == CH_RPAREN || c == CH_APOS ||
               c == CH_BTICK || c == CH_COMMA;
    endfunction

    logic       ws;
    logic       atom_end;
    logic       absorb;
    logic [1:0] lit_cls;
    logic [7:0] lit_chr;
    logic [7:0] c0;
    logic [7:0] c1;

    // #t, #f and #\c literal flags of the open atom
    always_comb
    begin
        c0      = ctl.first_chars[0];
        c1      = ctl.first_chars[1];
        lit_cls = LIT_NONE;
        lit_chr = 8'd0;
        if (c0 == CH_HASH)
        begin
            if (ctl.tok_length == 16'd2 && (c1 == CH_LO_T || c1 == CH_UP_T))
            begin
                lit_cls = LIT_TRUE;
            end
            else if (ctl.tok_length == 16'd2 && (c1 == CH_LO_F || c1 == CH_UP_F))
            begin
                lit_cls = LIT_FALSE;
            end
            else if (ctl.tok_length == 16'd3 && c1 == CH_BSLASH)
            begin
                lit_cls = LIT_CHAR;
                lit_chr = ctl.first_chars[2];
            end
        end
    end

    assign atom_end = is_space(text_byte) || text_byte == CH_LPAREN ||
                      text_byte == CH_RPAREN || text_byte == CH_SEMI;
    assign absorb   = text_byte == CH_LPAREN && ctl.tok_length == 16'd1 &&
                      (c0 == CH_HASH || c0 == CH_PCT);

    always_comb
    begin
        res       = '0;
        res.ctl   = ctl;
        res.kind  = KIND_PUNCT;
        res.err   = ERR_NONE;
        ws        = 1'b0;

        if (mode == MODE_END)
        begin
            res.clear = 1'b1;
            res.ctl   = CTL_RESET;
            if (ctl.pend_valid)
            begin
                res.emit   = 1'b1;
                res.kind   = KIND_PUNCT;
                res.length = 16'd1;
            end
            else
            begin
                case (ctl.scan_state)
                    ST_ATOM:
                    begin
                        res.emit      = 1'b1;
                        res.kind      = KIND_ATOM;
                        res.length    = ctl.tok_length;
                        res.lit_class = lit_cls;
                        res.lit_char  = lit_chr;
                    end
                    ST_STR:
                    begin
                        res.emit   = 1'b1;
                        res.kind   = KIND_ERROR;
                        res.length = ctl.tok_length;
                        res.err    = ERR_END_STRING;
                    end
                    ST_ATOM_ESC, ST_STR_ESC:
                    begin
                        res.emit   = 1'b1;
                        res.kind   = KIND_ERROR;
                        res.length = ctl.tok_length;
                        res.err    = ERR_END_ESCAPE;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else
        begin
            case (ctl.scan_state)
                ST_COMMENT:
                begin
                    if (text_byte == CH_NL)
                    begin
                        res.ctl.scan_state = ST_WS;
                    end
                end
                ST_ATOM, ST_ATOM_ESC:
                begin
                    if (ctl.scan_state == ST_ATOM && atom_end)
                    begin
                        res.ctl.scan_state = ST_WS;
                        res.emit           = 1'b1;
                        res.kind           = KIND_ATOM;
                        if (absorb)
                        begin
                            // "#(" or "%(": the paren belongs to the atom
                            res.ctl.first_chars[1] = text_byte;
                            res.ctl.tok_length     = 16'd2;
                            res.length             = 16'd2;
                        end
                        else
                        begin
                            res.length    = ctl.tok_length;
                            res.lit_class = lit_cls;
                            res.lit_char  = lit_chr;
                            ws            = 1'b1;
                        end
                    end
                    else
                    begin
                        if (ctl.tok_length < 16'd3)
                        begin
                            res.ctl.first_chars[ctl.tok_length[1:0]] = text_byte;
                        end
                        if (ctl.tok_length != LEN_MAX)
                        begin
                            res.ctl.tok_length = ctl.tok_length + 16'd1;
                        end
                        if (ctl.scan_state == ST_ATOM_ESC)
                        begin
                            res.ctl.scan_state = ST_ATOM;
                        end
                        else if (text_byte == CH_BSLASH)
                        begin
                            res.ctl.scan_state = ST_ATOM_ESC;
                        end
                    end
                end
                ST_STR:
                begin
                    if (text_byte == CH_QUOTE)
                    begin
                        res.emit           = 1'b1;
                        res.kind           = KIND_STRING;
                        res.length         = ctl.tok_length;
                        res.ctl.scan_state = ST_WS;
                    end
                    else
                    begin
                        if (ctl.tok_length != LEN_MAX)
                        begin
                            res.ctl.tok_length = ctl.tok_length + 16'd1;
                        end
                        if (text_byte == CH_BSLASH)
                        begin
                            res.ctl.scan_state = ST_STR_ESC;
                        end
                    end
                end
                ST_STR_ESC:
                begin
                    if (ctl.tok_length != LEN_MAX)
                    begin
                        res.ctl.tok_length = ctl.tok_length + 16'd1;
                    end
                    res.ctl.scan_state = ST_STR;
                end
                default:
                begin
                    res.ctl.scan_state = ST_WS;
                    ws                 = 1'b1;
                    if (ctl.pend_valid)
                    begin
                        res.ctl.pend_valid = 1'b0;
                        res.emit           = 1'b1;
                        res.kind           = KIND_PUNCT;
                        if (text_byte == CH_AT)
                        begin
                            res.length = 16'd2;
                            ws         = 1'b0;
                        end
                        else
                        begin
                            res.length = 16'd1;
                        end
                    end
                end
            endcase

            // byte seen from whitespace (also the byte that ends an atom)
            if (ws)
            begin
                if (is_space(text_byte))
                begin
                end
                else if (text_byte == CH_SEMI)
                begin
                    res.ctl.scan_state = ST_COMMENT;
                end
                else if (is_punct(text_byte))
                begin
                    res.mark_pre        = 1'b1;
                    res.ctl.tok_length  = 16'd0;
                    res.ctl.first_chars = '0;
                    res.ctl.pend_valid  = 1'b1;
                end
                else if (text_byte == CH_QUOTE)
                begin
                    res.mark_post       = 1'b1;
                    res.ctl.tok_length  = 16'd0;
                    res.ctl.first_chars = '0;
                    res.ctl.scan_state  = ST_STR;
                end
                else
                begin
                    res.mark_pre        = 1'b1;
                    res.ctl.tok_length  = 16'd1;
                    res.ctl.first_chars = {16'd0, text_byte};
                    res.ctl.scan_state  = (text_byte == CH_BSLASH) ? ST_ATOM_ESC : ST_ATOM;
                end
            end
        end
    end

endmodule

/* design/sexpr_tokenizer.sv */
// sexpr_tokenizer: top level of the byte-serial s-expression tokenizer.
// Depends on stx_pkg, stx_in_if/stx_out_if, stx_step and stx_pos.

// One text byte (or end-of-text marker) is taken per clock while the input
// is ready. The lexer state and position counters update at the edge that
// accepts the byte; a token caused by it appears in the output register on
// the next cycle. The input is ready whenever the output register is empty
// or its token is being taken in the same cycle, so with a ready consumer
// the block sustains one byte per cycle. Punctuation is reported one byte
// late, when the following byte (or end of text) shows whether an '@' joins
// it. tab_width may be written only while no request is in flight.
module sexpr_tokenizer
    import stx_pkg::*;
#(
    parameter int OFFSET_WIDTH = 24,
    parameter int ROW_WIDTH    = 20,
    parameter int COL_WIDTH    = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    stx_in_if.sink                    text,
    stx_out_if.source                 token,
    input  logic                      cfg_we,
    input  logic [TAB_WIDTH_BITS-1:0] cfg_data
);

    logic                      acc;
    step_t                     res;
    lex_ctl_t                  ctl_reg;
    logic [TAB_WIDTH_BITS-1:0] tab_width_reg;
    logic [OFFSET_WIDTH-1:0]   cur_offset_reg;
    logic [ROW_WIDTH-1:0]      cur_row_reg;
    logic [COL_WIDTH-1:0]      cur_column_reg;
    logic [OFFSET_WIDTH-1:0]   tok_offset_reg;
    logic [ROW_WIDTH-1:0]      tok_row_reg;
    logic [COL_WIDTH-1:0]      tok_column_reg;
    logic [OFFSET_WIDTH-1:0]   adv_offset;
    logic [ROW_WIDTH-1:0]      adv_row;
    logic [COL_WIDTH-1:0]      adv_column;

    logic                      out_valid_reg;
    logic [1:0]                kind_reg;
    logic [OFFSET_WIDTH-1:0]   offset_reg;
    logic [15:0]               length_reg;
    logic [ROW_WIDTH-1:0]      row_reg;
    logic [COL_WIDTH-1:0]      column_reg;
    logic [1:0]                lit_class_reg;
    logic [7:0]                lit_char_reg;
    logic [1:0]                err_reg;

    assign text.ready = !out_valid_reg || token.ready;
    assign acc        = text.valid && text.ready;

    stx_step u_step (
        .ctl       (ctl_reg),
        .mode      (text.mode),
        .text_byte (text.text_byte),
        .res       (res)
    );

    stx_pos #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .ROW_WIDTH    (ROW_WIDTH),
        .COL_WIDTH    (COL_WIDTH)
    ) u_pos (
        .cur_offset (cur_offset_reg),
        .cur_row    (cur_row_reg),
        .cur_column (cur_column_reg),
        .text_byte  (text.text_byte),
        .tab_width  (tab_width_reg),
        .adv_offset (adv_offset),
        .adv_row    (adv_row),
        .adv_column (adv_column)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_width_reg <= TAB_RESET;
        end
        else if (cfg_we)
        begin
            tab_width_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg        <= CTL_RESET;
            cur_offset_reg <= '0;
            cur_row_reg    <= ROW_WIDTH'(1);
            cur_column_reg <= '0;
            tok_offset_reg <= '0;
            tok_row_reg    <= '0;
            tok_column_reg <= '0;
        end
        else if (acc)
        begin
            ctl_reg <= res.ctl;
            if (res.clear)
            begin
                cur_offset_reg <= '0;
                cur_row_reg    <= ROW_WIDTH'(1);
                cur_column_reg <= '0;
                tok_offset_reg <= '0;
                tok_row_reg    <= '0;
                tok_column_reg <= '0;
            end
            else
            begin
                cur_offset_reg <= adv_offset;
                cur_row_reg    <= adv_row;
                cur_column_reg <= adv_column;
                if (res.mark_pre)
                begin
                    tok_offset_reg <= cur_offset_reg;
                    tok_row_reg    <= cur_row_reg;
                    tok_column_reg <= cur_column_reg;
                end
                else if (res.mark_post)
                begin
                    // strings start after the opening quote
                    tok_offset_reg <= adv_offset;
                    tok_row_reg    <= adv_row;
                    tok_column_reg <= adv_column;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (acc && res.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (token.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && res.emit)
        begin
            kind_reg      <= res.kind;
            offset_reg    <= tok_offset_reg;
            length_reg    <= res.length;
            row_reg       <= tok_row_reg;
            column_reg    <= tok_column_reg;
            lit_class_reg <= res.lit_class;
            lit_char_reg  <= res.lit_char;
            err_reg       <= res.err;
        end
    end

    assign token.valid         = out_valid_reg;
    assign token.token_kind    = kind_reg;
    assign token.start_offset  = offset_reg;
    assign token.token_length  = length_reg;
    assign token.start_row     = row_reg;
    assign token.start_column  = column_reg;
    assign token.literal_class = lit_class_reg;
    assign token.literal_char  = lit_char_reg;
    assign token.error_code    = err_reg;

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        acc && text.mode == MODE_END |=>
            ctl_reg.scan_state == ST_WS && !ctl_reg.pend_valid && cur_offset_reg == '0)
        else $error("end of text did not reset lexer state");

    a_row_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cur_row_reg != '0)
        else $error("row counter reached zero");

    a_pend_in_ws: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.pend_valid |-> ctl_reg.scan_state == ST_WS)
        else $error("held punctuation outside whitespace state");

    a_atom_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg.scan_state == ST_ATOM || ctl_reg.scan_state == ST_ATOM_ESC) |->
            ctl_reg.tok_length != 16'd0)
        else $error("open atom with zero length");

    a_token_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(acc))
        else $error("token appeared without an accepted request");

endmodule

/* tb/sexpr_tokenizer_test.sv */
// sexpr_tokenizer_test: self-checking bench for the s-expression tokenizer.
// Needs stx_pkg, stx_in_if / stx_out_if and sexpr_tokenizer; a lexer
// tracker inside the token scoreboard predicts every token.
`timescale 1ns / 100ps

import stx_pkg::*;

typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] offset;
    logic [15:0] length;
    logic [19:0] row;
    logic [15:0] column;
    logic [1:0]  lit_class;
    logic [7:0]  lit_char;
    logic [1:0]  err;
} token_t;

class token_scoreboard;
    logic [4:0]  tab_w;
    scan_state_t state;
    logic        held_valid;
    logic [19:0] row;
    logic [15:0] col;
    logic [23:0] off;
    logic [23:0] t_off;
    logic [19:0] t_row;
    logic [15:0] t_col;
    logic [15:0] t_len;
    logic [7:0]  head [3];
    token_t      tokens_due [$];
    int unsigned failures;

    function new();
        tab_w = TAB_RESET;
        failures = 0;
        clear_lexer();
    endfunction

    // end of text clears all lexer state except the tab width
    function void clear_lexer();
        state = ST_WS;
        held_valid = 1'b0;
        row = 20'd1;
        col = '0;
        off = '0;
        t_off = '0;
        t_row = '0;
        t_col = '0;
        t_len = '0;
        head = '{default: 8'h00};
    endfunction

    function void set_tab(logic [4:0] w);
        tab_w = w;
    endfunction

    function bit is_space(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_NL || b == CH_CR;
    endfunction

    function bit is_punct(logic [7:0] b);
        return b == CH_LPAREN || b == CH_RPAREN || b == CH_APOS || b == CH_BTICK ||
               b == CH_COMMA;
    endfunction

    function void advance(logic [7:0] b);
        int unsigned sum;
        if (off != '1)
            off++;
        if (b == CH_NL)
        begin
            if (row != '1)
                row++;
            col = '0;
        end
        else
        begin
            sum = (b == CH_TAB) ? col + tab_w : col + 1;
            col = (sum > 32'hFFFF) ? 16'hFFFF : sum[15:0];
        end
    endfunction

    function void mark();
        t_off = off;
        t_row = row;
        t_col = col;
        t_len = '0;
        head = '{default: 8'h00};
    endfunction

    function void append(logic [7:0] b);
        if (t_len < 3)
            head[t_len[1:0]] = b;
        if (t_len != LEN_MAX)
            t_len++;
    endfunction

    function void push(logic [1:0] kind, logic [15:0] len, logic [1:0] lit,
                       logic [7:0] ch, logic [1:0] err);
        token_t t;
        t.kind = kind;
        t.offset = t_off;
        t.length = len;
        t.row = t_row;
        t.column = t_col;
        t.lit_class = lit;
        t.lit_char = ch;
        t.err = err;
        tokens_due.push_back(t);
    endfunction

    function void push_atom();
        logic [1:0] lit;
        logic [7:0] ch;
        lit = LIT_NONE;
        ch = 8'h00;
        if (head[0] == CH_HASH)
        begin
            if (t_len == 2 && (head[1] == CH_LO_T || head[1] == CH_UP_T))
                lit = LIT_TRUE;
            else if (t_len == 2 && (head[1] == CH_LO_F || head[1] == CH_UP_F))
                lit = LIT_FALSE;
            else if (t_len == 3 && head[1] == CH_BSLASH)
            begin
                lit = LIT_CHAR;
                ch = head[2];
            end
        end
        push(KIND_ATOM, t_len, lit, ch, ERR_NONE);
    endfunction

    // byte seen between tokens; any held punctuation is already reported
    function void ws_byte(logic [7:0] b);
        if (is_space(b))
            advance(b);
        else if (b == CH_SEMI)
        begin
            advance(b);
            state = ST_COMMENT;
        end
        else if (is_punct(b))
        begin
            mark();
            held_valid = 1'b1;
            advance(b);
        end
        else if (b == CH_QUOTE)
        begin
            advance(b);
            mark();
            state = ST_STR;
        end
        else
        begin
            mark();
            append(b);
            advance(b);
            state = (b == CH_BSLASH) ? ST_ATOM_ESC : ST_ATOM;
        end
    endfunction

    function void note_request(logic m, logic [7:0] b);
        if (m == MODE_END)
        begin
            if (held_valid)
                push(KIND_PUNCT, 16'd1, LIT_NONE, 8'h00, ERR_NONE);
            else if (state == ST_ATOM)
                push_atom();
            else if (state == ST_STR)
                push(KIND_ERROR, t_len, LIT_NONE, 8'h00, ERR_END_STRING);
            else if (state == ST_ATOM_ESC || state == ST_STR_ESC)
                push(KIND_ERROR, t_len, LIT_NONE, 8'h00, ERR_END_ESCAPE);
            clear_lexer();
            return;
        end
        case (state)
            ST_COMMENT:
            begin
                if (b == CH_NL)
                    state = ST_WS;
                advance(b);
            end
            ST_ATOM:
            begin
                if (is_space(b) || b == CH_LPAREN || b == CH_RPAREN || b == CH_SEMI)
                begin
                    state = ST_WS;
                    // lone '#' or '%' swallows an opening paren
                    if (b == CH_LPAREN && t_len == 1 &&
                        (head[0] == CH_HASH || head[0] == CH_PCT))
                    begin
                        append(b);
                        advance(b);
                        push_atom();
                    end
                    else
                    begin
                        push_atom();
                        ws_byte(b);
                    end
                end
                else
                begin
                    append(b);
                    advance(b);
                    if (b == CH_BSLASH)
                        state = ST_ATOM_ESC;
                end
            end
            ST_ATOM_ESC:
            begin
                append(b);
                advance(b);
                state = ST_ATOM;
            end
            ST_STR:
            begin
                if (b == CH_QUOTE)
                begin
                    push(KIND_STRING, t_len, LIT_NONE, 8'h00, ERR_NONE);
                    state = ST_WS;
                end
                else
                begin
                    if (t_len != LEN_MAX)
                        t_len++;
                    if (b == CH_BSLASH)
                        state = ST_STR_ESC;
                end
                advance(b);
            end
            ST_STR_ESC:
            begin
                if (t_len != LEN_MAX)
                    t_len++;
                advance(b);
                state = ST_STR;
            end
            default:
            begin
                state = ST_WS;
                if (held_valid)
                begin
                    held_valid = 1'b0;
                    if (b == CH_AT)
                    begin
                        push(KIND_PUNCT, 16'd2, LIT_NONE, 8'h00, ERR_NONE);
                        advance(b);
                        return;
                    end
                    push(KIND_PUNCT, 16'd1, LIT_NONE, 8'h00, ERR_NONE);
                end
                ws_byte(b);
            end
        endcase
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    function void check_token(token_t got);
        token_t want;
        if (tokens_due.size() == 0)
        begin
            $error("token with none outstanding: kind %0d offset %0d", got.kind, got.offset);
            failures++;
            return;
        end
        want = tokens_due.pop_front();
        compare("token_kind", want.kind, got.kind);
        compare("start_offset", want.offset, got.offset);
        compare("token_length", want.length, got.length);
        compare("start_row", want.row, got.row);
        compare("start_column", want.column, got.column);
        compare("literal_class", want.lit_class, got.lit_class);
        compare("literal_char", want.lit_char, got.lit_char);
        compare("error_code", want.err, got.err);
    endfunction
endclass

module sexpr_tokenizer_test;

    localparam int unsigned CYCLE_LIMIT = 200_000;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [TAB_WIDTH_BITS-1:0] cfg_data;
    bit                        steady;
    int unsigned               sent;
    int unsigned               cycle_count = 0;
    token_scoreboard           sb;

    stx_in_if  in_ch ();
    stx_out_if #(.OFFSET_WIDTH(24), .ROW_WIDTH(20), .COL_WIDTH(16)) out_ch ();

    sexpr_tokenizer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (in_ch),
        .token    (out_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("sexpr_tokenizer_test NOT OK");
            $finish;
        end
    end

    // token sink with random back-pressure outside steady phases
    always @(posedge clk)
    begin : take_token
        token_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.kind = out_ch.token_kind;
            got.offset = out_ch.start_offset;
            got.length = out_ch.token_length;
            got.row = out_ch.start_row;
            got.column = out_ch.start_column;
            got.lit_class = out_ch.literal_class;
            got.lit_char = out_ch.literal_char;
            got.err = out_ch.error_code;
            sb.check_token(got);
        end
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 12);
    end

    task automatic send_request(input logic m, input logic [7:0] b);
        if (!steady && $urandom_range(0, 99) < 12)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= m;
        in_ch.text_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_request(m, b);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_request(MODE_TEXT, s[i]);
    endtask

    // drain all outstanding tokens, then leave the block quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.tokens_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_tab_width(input logic [4:0] w);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= w;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.set_tab(w);
    endtask

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_NL;
            default: return CH_CR;
        endcase
    endfunction

    // any byte that keeps an atom going
    function automatic logic [7:0] atom_char();
        logic [7:0] c;
        c = $urandom_range(0, 1) ? 8'($urandom_range(33, 126)) : 8'($urandom_range(0, 255));
        while (c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR ||
               c == CH_LPAREN || c == CH_RPAREN || c == CH_SEMI)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic end_atom();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: send_request(MODE_TEXT, ws_char());
            4: send_request(MODE_TEXT, CH_LPAREN);
            5: send_request(MODE_TEXT, CH_RPAREN);
            6:
            begin
                send_request(MODE_TEXT, CH_SEMI);
                send_request(MODE_TEXT, CH_NL);
            end
            7: send_request(MODE_END, 8'($urandom_range(0, 255)));
            default: ;  // let the next token run into this one
        endcase
    endtask

    task automatic random_token();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  c;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            send_request(MODE_END, 8'($urandom_range(0, 255)));
        else if (pick < 12)
            send_request(MODE_TEXT, 8'($urandom_range(0, 255)));
        else if (pick < 26)
            send_request(MODE_TEXT, ws_char());
        else if (pick < 42)
        begin
            case ($urandom_range(0, 4))
                0: c = CH_LPAREN;
                1: c = CH_RPAREN;
                2: c = CH_APOS;
                3: c = CH_BTICK;
                default: c = CH_COMMA;
            endcase
            send_request(MODE_TEXT, c);
            if ($urandom_range(0, 9) < 3)
                send_request(MODE_TEXT, CH_AT);
        end
        else if (pick < 49)
        begin
            send_request(MODE_TEXT, CH_SEMI);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
            begin
                c = 8'($urandom_range(0, 255));
                send_request(MODE_TEXT, (c == CH_NL) ? CH_SPACE : c);
            end
            send_request(MODE_TEXT, CH_NL);
        end
        else if (pick < 62)
        begin
            case ($urandom_range(0, 7))
                0: send_text("#t");
                1: send_text("#T");
                2: send_text("#f");
                3: send_text("#F");
                4:
                begin
                    send_text("#\\");
                    send_request(MODE_TEXT, 8'($urandom_range(0, 255)));
                end
                5: send_text("#(");
                6: send_text("%(");
                default:
                begin
                    send_request(MODE_TEXT, CH_HASH);
                    send_request(MODE_TEXT, atom_char());
                end
            endcase
            end_atom();
        end
        else if (pick < 80)
        begin
            n = $urandom_range(1, 6);
            c = atom_char();
            while (c == CH_QUOTE || c == CH_APOS || c == CH_BTICK || c == CH_COMMA)
                c = atom_char();
            if ($urandom_range(0, 9) == 0)
                c = CH_AT;
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                    c = atom_char();
                send_request(MODE_TEXT, c);
                if (c == CH_BSLASH)
                    send_request(MODE_TEXT, 8'($urandom_range(0, 255)));
            end
            end_atom();
        end
        else
        begin
            send_request(MODE_TEXT, CH_QUOTE);
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    send_request(MODE_TEXT, CH_BSLASH);
                    send_request(MODE_TEXT, 8'($urandom_range(0, 255)));
                end
                else
                begin
                    c = 8'($urandom_range(0, 255));
                    while (c == CH_QUOTE || c == CH_BSLASH)
                        c = 8'($urandom_range(0, 255));
                    send_request(MODE_TEXT, c);
                end
            end
            // an unclosed string now and then
            if ($urandom_range(0, 9) != 0)
                send_request(MODE_TEXT, CH_QUOTE);
        end
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned stop;
        stop = sent + count;
        while (sent < stop)
            random_token();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = TAB_RESET;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_TEXT;
        in_ch.text_byte = 8'h00;
        out_ch.ready = 1'b0;
        steady = 1'b0;
        sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset tab width, punctuation pairs, literals, absorbed paren,
        // comment, escaped quote, end inside string and inside escape
        send_text("(,@#T\t#\\x)");
        send_request(MODE_END, 8'h00);
        send_text("@ #(%x;\n\"\\\"");
        send_request(MODE_END, 8'hFF);
        send_request(MODE_TEXT, 8'hFF);
        send_request(MODE_TEXT, 8'h00);
        send_request(MODE_TEXT, CH_BSLASH);
        send_request(MODE_END, 8'h00);

        set_tab_width(5'd1);
        random_phase(210);
        set_tab_width(5'd16);
        random_phase(210);

        set_tab_width(5'd0);
        steady = 1'b1;
        random_phase(210);
        steady = 1'b0;

        set_tab_width(5'd31);
        random_phase(210);

        set_tab_width(5'($urandom_range(0, 31)));
        random_phase(210);
        send_request(MODE_END, 8'h00);
        settle();

        if (sb.failures == 0 && sb.tokens_due.size() == 0)
            $display("sexpr_tokenizer_test OK");
        else
            $display("sexpr_tokenizer_test NOT OK");
        $finish;
    end

endmodule
